### design/greedy_box_overlap_suppression_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box suppression core
// Short forms for clocked properties that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_OVERLAP_SUPPRESSION_CORE_MACROS_SVH
`define GREEDY_BOX_OVERLAP_SUPPRESSION_CORE_MACROS_SVH

// Same-cycle implication.
`define GBOS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbos assertion failed");

// Next-cycle implication.
`define GBOS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbos assertion failed");

`endif

### design/gbos_pkg.sv
// ----------------------------------------------------------------------------
// gbos_pkg
// Shared constants and types of the greedy box suppression core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbos_pkg;

  // Default sizes of the kept-box chain and of the used coordinate bits.
  localparam int MaxKeptDef   = 64;
  localparam int CoordBitsDef = 12;

  // Width of each coordinate field on the request channel.
  localparam int FieldBits = 12;

  // Threshold register: fraction with eight fraction bits.
  localparam int              ThrBits  = 9;
  localparam logic [ThrBits-1:0] ThrReset = 9'd77;
  localparam int              FracOne  = 256;

  // Control that travels with a request along the chain of cells.
  typedef struct packed {
    logic valid;
    logic sup;
  } tok_ctl_t;

endpackage

`default_nettype wire

### design/gbos_ifs.sv
// ----------------------------------------------------------------------------
// gbos channel interfaces
// Box request channel and decision result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbos_box_if;
  logic                          valid;
  logic                          ready;
  logic [gbos_pkg::FieldBits-1:0] left;
  logic [gbos_pkg::FieldBits-1:0] upper;
  logic [gbos_pkg::FieldBits-1:0] right;
  logic [gbos_pkg::FieldBits-1:0] lower;
  logic                          last_box;

  modport source (output valid, left, upper, right, lower, last_box, input ready);
  modport sink   (input valid, left, upper, right, lower, last_box, output ready);
endinterface

interface gbos_res_if;
  logic valid;
  logic ready;
  logic keep;
  logic store_full;
  logic last_out;

  modport source (output valid, keep, store_full, last_out, input ready);
  modport sink   (input valid, keep, store_full, last_out, output ready);
endinterface

`default_nettype wire

### design/gbos_cell.sv
// ----------------------------------------------------------------------------
// gbos_cell
// One slot of the kept-box chain: holds a kept box and its area, checks a
// passing request against it in two stages and hands the request onward.
// ----------------------------------------------------------------------------
`default_nettype none

module gbos_cell #(
  parameter int INDEX      = 0,
  parameter int COORD_BITS = gbos_pkg::CoordBitsDef,
  parameter int CNT_W      = 7
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic [gbos_pkg::ThrBits-1:0]    thr_i,
  input  wire logic [CNT_W-1:0]                count_i,
  input  wire gbos_pkg::tok_ctl_t              in_ctl_i,
  input  wire logic [4*COORD_BITS-1:0]         in_box_i,
  output gbos_pkg::tok_ctl_t                   out_ctl_o,
  output logic [4*COORD_BITS-1:0]              out_box_o,
  output gbos_pkg::tok_ctl_t                   done_o
);

  localparam int Cb    = COORD_BITS;
  localparam int BoxW  = 4 * Cb;
  localparam int SpanW = Cb + 1;
  localparam int AreaW = 2 * SpanW;
  localparam int SumW  = AreaW + 1;
  localparam int FacW  = gbos_pkg::ThrBits + 1;
  localparam int CmpW  = AreaW + FacW;

  // Inclusive extent of lo..hi, zero when the span is inverted.
  function automatic logic [SpanW-1:0] span(input logic [Cb-1:0] lo,
                                            input logic [Cb-1:0] hi);
    logic [Cb-1:0] diff;
    diff = hi - lo;
    return (hi >= lo) ? ({1'b0, diff} + SpanW'(1)) : '0;
  endfunction

  function automatic logic [Cb-1:0] cmax(input logic [Cb-1:0] a, input logic [Cb-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [Cb-1:0] cmin(input logic [Cb-1:0] a, input logic [Cb-1:0] b);
    return (a < b) ? a : b;
  endfunction

  gbos_pkg::tok_ctl_t a_ctl_q, b_ctl_q;
  logic [BoxW-1:0]  a_box_q, b_box_q, st_box_q;
  logic [AreaW-1:0] st_area_q, b_inter_q;
  logic [SumW-1:0]  b_sum_q;

  logic             end_here;
  logic             store_en;
  logic [Cb-1:0]    nx0, ny0, nx1, ny1, kx0, ky0, kx1, ky1;
  logic [AreaW-1:0] area_new, inter;
  logic [SumW-1:0]  sum_d;
  logic [FacW-1:0]  factor;
  logic [CmpW-1:0]  lhs, rhs;
  logic             hit;

  // This slot is the end of the list when the count points at it.
  assign end_here = (count_i == CNT_W'(INDEX));
  assign store_en = en_i && a_ctl_q.valid && end_here && !a_ctl_q.sup;

  assign done_o.valid = a_ctl_q.valid && end_here;
  assign done_o.sup   = a_ctl_q.sup;

  // First stage: area of the request and intersection with the kept box.
  always_comb begin
    nx0 = a_box_q[0*Cb +: Cb];
    ny0 = a_box_q[1*Cb +: Cb];
    nx1 = a_box_q[2*Cb +: Cb];
    ny1 = a_box_q[3*Cb +: Cb];
    kx0 = st_box_q[0*Cb +: Cb];
    ky0 = st_box_q[1*Cb +: Cb];
    kx1 = st_box_q[2*Cb +: Cb];
    ky1 = st_box_q[3*Cb +: Cb];
    area_new = AreaW'(span(nx0, nx1)) * AreaW'(span(ny0, ny1));
    inter    = AreaW'(span(cmax(nx0, kx0), cmin(nx1, kx1)))
             * AreaW'(span(cmax(ny0, ky0), cmin(ny1, ky1)));
    sum_d    = SumW'(area_new) + SumW'(st_area_q);
  end

  // Second stage: inter*(256+thr) >= thr*(areaA+areaB) is the IoU test.
  always_comb begin
    factor = FacW'(gbos_pkg::FracOne) + FacW'(thr_i);
    lhs    = CmpW'(b_inter_q) * CmpW'(factor);
    rhs    = CmpW'(b_sum_q) * CmpW'(thr_i);
    hit    = (lhs >= rhs);
  end

  assign out_ctl_o.valid = b_ctl_q.valid;
  assign out_ctl_o.sup   = b_ctl_q.sup | hit;
  assign out_box_o       = b_box_q;

  // Request control through the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
    end else if (en_i) begin
      a_ctl_q       <= in_ctl_i;
      b_ctl_q.valid <= a_ctl_q.valid && !end_here;
      b_ctl_q.sup   <= a_ctl_q.sup;
    end
  end

  // Request payload through the two stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_box_q   <= in_box_i;
      b_box_q   <= a_box_q;
      b_inter_q <= inter;
      b_sum_q   <= sum_d;
    end
  end

  // Kept box of this slot, written when a surviving request ends here.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      st_box_q  <= a_box_q;
      st_area_q <= area_new;
    end
  end

endmodule

`default_nettype wire

### design/greedy_box_overlap_suppression_core.sv
// ----------------------------------------------------------------------------
// greedy_box_overlap_suppression_core
// Greedy IoU suppression of a box stream against the boxes kept so far.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Contents
//  box_i     in   valid/ready    left, upper, right, lower, last_box
//  res_o     out  valid/ready    keep, store_full, last_out
//  cfg       in   write enable   overlap threshold, 9 bits
//
//  A request walks the chain of cells in order and ends at the slot the kept
//  count points to, or runs off the end of the chain once the store is full.
//  One request is in flight at a time; the next one is taken once the
//  decision is in the result register. A stalled result freezes the chain
//  when a further decision is waiting. Reset empties the list and loads the
//  threshold default.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_box_overlap_suppression_core_macros.svh"

module greedy_box_overlap_suppression_core #(
  parameter int MAX_KEPT   = gbos_pkg::MaxKeptDef,
  parameter int COORD_BITS = gbos_pkg::CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gbos_pkg::ThrBits-1:0] cfg_data_i,
  gbos_box_if.sink                          box_i,
  gbos_res_if.source                        res_o
);

  localparam int Cb      = COORD_BITS;
  localparam int BoxW    = 4 * Cb;
  localparam int CntW    = $clog2(MAX_KEPT + 1);
  localparam int UseBits = (Cb < gbos_pkg::FieldBits) ? Cb : gbos_pkg::FieldBits;

  logic [gbos_pkg::ThrBits-1:0] thr_q;
  logic [CntW-1:0]              count_q;
  logic                         busy_q, ent_valid_q, last_q;
  logic [BoxW-1:0]              ent_box_q;
  logic                         out_valid_q, out_keep_q, out_full_q, out_last_q;

  gbos_pkg::tok_ctl_t ctl  [MAX_KEPT+1];
  logic [BoxW-1:0]    bx   [MAX_KEPT+1];
  gbos_pkg::tok_ctl_t done [MAX_KEPT];
  logic [MAX_KEPT:0]  done_vec;

  logic accept, fin_valid, fin_sup, fin_full, fin_keep, en, fin_take;

  assign accept      = box_i.valid && box_i.ready;
  assign box_i.ready = !busy_q;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= gbos_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Entry register in front of the first cell.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_box_q <= {Cb'(box_i.lower[UseBits-1:0]), Cb'(box_i.right[UseBits-1:0]),
                    Cb'(box_i.upper[UseBits-1:0]), Cb'(box_i.left[UseBits-1:0])};
      last_q    <= box_i.last_box;
    end
  end

  assign ctl[0].valid = ent_valid_q;
  assign ctl[0].sup   = 1'b0;
  assign bx[0]        = ent_box_q;

  // Chain of kept-box cells.
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbos_cell #(
      .INDEX      (i),
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .thr_i     (thr_q),
      .count_i   (count_q),
      .in_ctl_i  (ctl[i]),
      .in_box_i  (bx[i]),
      .out_ctl_o (ctl[i+1]),
      .out_box_o (bx[i+1]),
      .done_o    (done[i])
    );
    assign done_vec[i] = done[i].valid;
  end
  assign done_vec[MAX_KEPT] = ctl[MAX_KEPT].valid;

  // Gather the decision from whichever slot ended the request.
  always_comb begin
    fin_sup = ctl[MAX_KEPT].valid && ctl[MAX_KEPT].sup;
    for (int i = 0; i < MAX_KEPT; i++) begin
      fin_sup = fin_sup | (done[i].valid & done[i].sup);
    end
  end

  assign fin_valid = |done_vec;
  assign fin_full  = ctl[MAX_KEPT].valid;
  assign fin_keep  = !fin_sup;
  assign en        = !(fin_valid && out_valid_q && !res_o.ready);
  assign fin_take  = fin_valid && en;

  // Request tracking and the kept count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ent_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        busy_q      <= 1'b1;
        ent_valid_q <= 1'b1;
      end else if (en) begin
        ent_valid_q <= 1'b0;
      end
      if (fin_take) begin
        busy_q <= 1'b0;
        if (last_q) begin
          count_q <= '0;
        end else if (fin_keep && !fin_full) begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      out_keep_q <= fin_keep;
      out_full_q <= fin_keep && fin_full;
      out_last_q <= last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.keep       = out_keep_q;
  assign res_o.store_full = out_full_q;
  assign res_o.last_out   = out_last_q;

  // Checks on the chain and the result.
  `GBOS_ASSERT_IMP(a_one_end, clk_i, rst_ni, 1'b1, $onehot0(done_vec))
  `GBOS_ASSERT_IMP(a_end_busy, clk_i, rst_ni, fin_valid, busy_q)
  `GBOS_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CntW'(MAX_KEPT))
  `GBOS_ASSERT_IMP(a_full_keep, clk_i, rst_ni, out_valid_q && out_full_q, out_keep_q)
  `GBOS_ASSERT_NXT(a_take_idle, clk_i, rst_ni, fin_take, box_i.ready)

endmodule

`default_nettype wire
